### hdl/fpa_pkg.sv
// ----------------------------------------------------------------------------
// fpa_pkg
// Shared types, constants and saturation helpers of the fixed-point ALU.
// ----------------------------------------------------------------------------
package fpa_pkg;

  localparam int FRAC_BITS  = 8;
  localparam int NUM_W      = 32 + FRAC_BITS;
  localparam int DIV_BITS   = 2;
  localparam int DIV_STAGES = (NUM_W + DIV_BITS - 1) / DIV_BITS;

  typedef enum logic [3:0] {
    OP_ADD = 4'd0, OP_SUB = 4'd1, OP_MUL = 4'd2, OP_DIV = 4'd3,
    OP_GT = 4'd4, OP_LT = 4'd5, OP_GE = 4'd6, OP_LE = 4'd7,
    OP_EQ = 4'd8, OP_NE = 4'd9, OP_MIN = 4'd10, OP_MAX = 4'd11,
    OP_INC = 4'd12, OP_DEC = 4'd13, OP_TO_INT = 4'd14, OP_FROM_INT = 4'd15
  } op_t;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_OVF  = 2'd1;
  localparam logic [1:0] ST_DIV0 = 2'd2;

  typedef struct packed {
    logic [31:0] val;
    logic        ovf;
  } sat_t;

  typedef struct packed {
    op_t              kind;
    logic [31:0]      res;
    logic             cmp;
    logic [1:0]       status;
    logic             neg;
    logic [63:0]      prod;
    logic [NUM_W-1:0] num;
    logic [32:0]      rem;
    logic [31:0]      den;
  } pl_t;

  // Builds a 32-bit word from sign and magnitude, clamping to the range.
  function automatic sat_t pack_mag(logic neg, logic [63:0] mag);
    sat_t r;
    r.ovf = 1'b0;
    if (neg) begin
      if (mag > 64'h0000_0000_8000_0000) begin
        r.ovf = 1'b1;
        r.val = 32'h8000_0000;
      end else begin
        r.val = ~mag[31:0] + 32'd1;
      end
    end else if (mag > 64'h0000_0000_7FFF_FFFF) begin
      r.ovf = 1'b1;
      r.val = 32'h7FFF_FFFF;
    end else begin
      r.val = mag[31:0];
    end
    return r;
  endfunction

  function automatic sat_t sat_wide(logic [63:0] v);
    return pack_mag(v[63], v[63] ? (~v + 64'd1) : v);
  endfunction

endpackage

### hdl/fixed_point_alu.sv
// ----------------------------------------------------------------------------
// fixed_point_alu
// Signed fixed-point ALU with FRAC_BITS fraction bits on 32-bit raw words.
// ----------------------------------------------------------------------------
// Usage: each input transaction carries an operation code in in_tuser and
// the two raw operands in in_tdata. Every transaction yields exactly one
// result transaction on the out_ channel, in order.
// Every operation passes through the same stages: one decode and multiply
// stage, the divider stages that produce two quotient bits each, and one
// rounding and saturation stage. All operations share that pipeline, so one
// transaction is accepted every cycle unless the output stalls; the depth is
// set by the restoring divider.
// Reset clears all stage valid bits; the block accepts input as soon as
// reset is released. When the receiver holds out_tready low with a result
// waiting, the whole pipeline freezes and in_tready goes low; nothing is
// dropped or repeated, and the pipe fills bubbles while the output is free.
// ----------------------------------------------------------------------------
module fixed_point_alu import fpa_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // [31:0] a_value, [63:32] b_value
  input  logic [3:0]  in_tuser,   // [3:0] kind
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [31:0] result_value
  output logic [2:0]  out_tuser   // [0] compare_true, [2:1] status
);

  logic en;
  logic f_vld, d_vld;
  pl_t  f_pl, d_pl;
  logic        cmp;
  logic [1:0]  status;

  assign en        = out_tready | ~out_tvalid;
  assign in_tready = en;

  fpa_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_vld  (in_tvalid),
    .kind_in (in_tuser),
    .a_in    (in_tdata[31:0]),
    .b_in    (in_tdata[63:32]),
    .vld_o   (f_vld),
    .pl_o    (f_pl)
  );

  fpa_div_pipe u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .vld_i (f_vld),
    .pl_i  (f_pl),
    .vld_o (d_vld),
    .pl_o  (d_pl)
  );

  fpa_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .vld_i    (d_vld),
    .pl_i     (d_pl),
    .vld_o    (out_tvalid),
    .res_o    (out_tdata),
    .cmp_o    (cmp),
    .status_o (status)
  );

  assign out_tuser = {status, cmp};

endmodule

### hdl/fpa_front.sv
// ----------------------------------------------------------------------------
// fpa_front
// First stage: decode, add/sub/compare/min/max/shift results, product, divider setup.
// ----------------------------------------------------------------------------
module fpa_front import fpa_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        en,
  input  logic        in_vld,
  input  logic [3:0]  kind_in,
  input  logic [31:0] a_in,
  input  logic [31:0] b_in,
  output logic        vld_o,
  output pl_t         pl_o
);

  logic        vld_r;
  pl_t         pl_r, pl_nxt;
  logic signed [63:0] aw, bw;
  logic [31:0] ma, mb;
  sat_t        s;

  always_comb begin
    aw = 64'(signed'(a_in));
    bw = 64'(signed'(b_in));
    ma = a_in[31] ? (~a_in + 32'd1) : a_in;
    mb = b_in[31] ? (~b_in + 32'd1) : b_in;
    s  = '0;
    pl_nxt        = '0;
    pl_nxt.kind   = op_t'(kind_in);
    pl_nxt.neg    = a_in[31] ^ b_in[31];
    pl_nxt.prod   = 64'(ma) * 64'(mb);
    pl_nxt.num    = NUM_W'(ma) << FRAC_BITS;
    pl_nxt.den    = mb;
    pl_nxt.status = ST_OK;
    case (op_t'(kind_in))
      OP_ADD:      s = sat_wide(64'(aw + bw));
      OP_SUB:      s = sat_wide(64'(aw - bw));
      OP_INC:      s = sat_wide(64'(aw + 64'sd1));
      OP_DEC:      s = sat_wide(64'(aw - 64'sd1));
      OP_FROM_INT: s = sat_wide(64'(aw <<< FRAC_BITS));
      default:     s = '0;
    endcase
    case (op_t'(kind_in))
      OP_ADD, OP_SUB, OP_INC, OP_DEC, OP_FROM_INT: begin
        pl_nxt.res    = s.val;
        pl_nxt.status = s.ovf ? ST_OVF : ST_OK;
      end
      OP_GT:     pl_nxt.cmp = aw > bw;
      OP_LT:     pl_nxt.cmp = aw < bw;
      OP_GE:     pl_nxt.cmp = aw >= bw;
      OP_LE:     pl_nxt.cmp = aw <= bw;
      OP_EQ:     pl_nxt.cmp = aw == bw;
      OP_NE:     pl_nxt.cmp = aw != bw;
      OP_MIN:    pl_nxt.res = (aw <= bw) ? a_in : b_in;
      OP_MAX:    pl_nxt.res = (aw >= bw) ? a_in : b_in;
      OP_TO_INT: pl_nxt.res = 32'(aw >>> FRAC_BITS);
      default:   pl_nxt.res = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pl_r <= pl_nxt;
    end
  end

  assign vld_o = vld_r;
  assign pl_o  = pl_r;

endmodule

### hdl/fpa_div_pipe.sv
// ----------------------------------------------------------------------------
// fpa_div_pipe
// Restoring divider, DIV_BITS quotient bits per register stage.
// ----------------------------------------------------------------------------
module fpa_div_pipe import fpa_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic en,
  input  logic vld_i,
  input  pl_t  pl_i,
  output logic vld_o,
  output pl_t  pl_o
);

  logic vld_r [DIV_STAGES];
  pl_t  pl_r  [DIV_STAGES];
  pl_t  pl_nxt[DIV_STAGES];

  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
    pl_t  src;
    logic src_vld;
    if (s == 0) begin : g_first
      assign src     = pl_i;
      assign src_vld = vld_i;
    end else begin : g_next
      assign src     = pl_r[s-1];
      assign src_vld = vld_r[s-1];
    end

    always_comb begin
      logic [32:0] rem_sh;
      logic [33:0] trial;
      pl_nxt[s] = src;
      for (int j = 0; j < DIV_BITS; j++) begin
        // The last stage may have fewer numerator bits left than its width.
        if (s * DIV_BITS + j < NUM_W) begin
          rem_sh = {pl_nxt[s].rem[31:0], pl_nxt[s].num[NUM_W-1]};
          trial  = {1'b0, rem_sh} - {2'b00, pl_nxt[s].den};
          pl_nxt[s].rem = trial[33] ? rem_sh : trial[32:0];
          pl_nxt[s].num = {pl_nxt[s].num[NUM_W-2:0], ~trial[33]};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s] <= 1'b0;
      end else if (en) begin
        vld_r[s] <= src_vld;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        pl_r[s] <= pl_nxt[s];
      end
    end
  end

  assign vld_o = vld_r[DIV_STAGES-1];
  assign pl_o  = pl_r[DIV_STAGES-1];

endmodule

### hdl/fpa_back.sv
// ----------------------------------------------------------------------------
// fpa_back
// Last stage: rounding and saturation of products and quotients, divide-by-zero status, output reg.
// ----------------------------------------------------------------------------
module fpa_back import fpa_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        en,
  input  logic        vld_i,
  input  pl_t         pl_i,
  output logic        vld_o,
  output logic [31:0] res_o,
  output logic        cmp_o,
  output logic [1:0]  status_o
);

  logic        vld_r;
  logic [31:0] res_r, res_nxt;
  logic        cmp_r;
  logic [1:0]  status_r, status_nxt;
  logic [63:0] q;
  logic        up;
  sat_t        s;

  always_comb begin
    up  = {pl_i.rem, 1'b0} >= {2'b00, pl_i.den};
    q   = '0;
    case (pl_i.kind)
      OP_MUL:  q = (pl_i.prod + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
      OP_DIV:  q = 64'(pl_i.num) + 64'(up);
      default: q = '0;
    endcase
    s          = pack_mag(pl_i.neg && (q != 64'd0), q);
    res_nxt    = pl_i.res;
    status_nxt = pl_i.status;
    case (pl_i.kind)
      OP_MUL: begin
        res_nxt    = s.val;
        status_nxt = s.ovf ? ST_OVF : ST_OK;
      end
      OP_DIV: begin
        if (pl_i.den == 32'd0) begin
          res_nxt    = '0;
          status_nxt = ST_DIV0;
        end else begin
          res_nxt    = s.val;
          status_nxt = s.ovf ? ST_OVF : ST_OK;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_r    <= res_nxt;
      cmp_r    <= pl_i.cmp;
      status_r <= status_nxt;
    end
  end

  assign vld_o    = vld_r;
  assign res_o    = res_r;
  assign cmp_o    = cmp_r;
  assign status_o = status_r;

endmodule
